// ===== rtl/falling_sand_grid_engine_unit_defines.svh =====
// Assertion macros for the falling sand grid engine.
// Used by the top level only; expects aclk and aresetn in scope.
`ifndef FALLING_SAND_GRID_ENGINE_UNIT_DEFINES_SVH
`define FALLING_SAND_GRID_ENGINE_UNIT_DEFINES_SVH

// consequent checked in the same cycle
`define FSG_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the next cycle
`define FSG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/fsg_pkg.sv =====
// Shared types and codes for the falling sand grid engine.
// No dependencies.
package fsg_pkg;

    localparam int CFG_W_BITS = 10;
    localparam int CFG_H_BITS = 9;
    localparam int CFG_DATA_W = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int RADC_W     = 8;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;

    localparam logic [1:0] CMD_SWEEP = 2'd0;
    localparam logic [1:0] CMD_PAINT = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam logic [1:0] CELL_EMPTY = 2'd0;
    localparam logic [1:0] CELL_SAND  = 2'd1;
    localparam logic [1:0] CELL_WATER = 2'd2;
    localparam logic [1:0] CELL_STONE = 2'd3;

    // move candidates in order of preference
    localparam logic [2:0] CAND_BELOW = 3'd0;
    localparam logic [2:0] CAND_BLEFT = 3'd1;
    localparam logic [2:0] CAND_BRIGHT = 3'd2;
    localparam logic [2:0] CAND_LEFT  = 3'd3;
    localparam logic [2:0] CAND_RIGHT = 3'd4;

    typedef struct packed {
        logic [1:0] command;
        logic [8:0] col;
        logic [7:0] row;
        logic [5:0] radius;
        logic [1:0] material;
    } fsg_in_t;

    typedef struct packed {
        logic [1:0] cell_value;
        logic       accepted;
    } fsg_out_t;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_READ_WAIT,
        ST_PAINT_INIT,
        ST_PAINT_BASE,
        ST_PAINT_RD,
        ST_PAINT_CHK,
        ST_SWEEP_INIT,
        ST_SWEEP_START,
        ST_VISIT_RD,
        ST_VISIT_CHK,
        ST_CAND_SEL,
        ST_CAND_CHK,
        ST_MOVE_SRC,
        ST_MARK_CLR,
        ST_TAIL_CLR,
        ST_DONE
    } fsg_state_t;

endpackage

// ===== rtl/fsg_ram.sv =====
// Single-port synchronous RAM, registered read.
// Holds grid cells or moved marks; no dependencies.
module fsg_ram #(
    parameter int DEPTH  = 4,
    parameter int DATA_W = 1,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              en,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  logic [DATA_W-1:0] wdata,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

// ===== rtl/fsg_ctrl.sv =====
// Command sequencer: sweep, paint and read over the cell and mark RAMs.
// Depends on fsg_pkg.
module fsg_ctrl import fsg_pkg::*; #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 256,
    parameter int MAX_RADIUS = 50,
    localparam int ADDR_W = $clog2(MAX_WIDTH * MAX_HEIGHT)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [CFG_W_BITS-1:0] cfg_width,
    input  logic [CFG_H_BITS-1:0] cfg_height,
    input  logic                  start,
    input  fsg_in_t               item,
    output logic                  idle,
    output logic                  res_valid,
    output fsg_out_t              res,
    input  logic                  res_ready,
    output logic                  cell_en,
    output logic                  cell_we,
    output logic [ADDR_W-1:0]     cell_addr,
    output logic [1:0]            cell_wdata,
    input  logic [1:0]            cell_rdata,
    output logic                  mark_en,
    output logic                  mark_we,
    output logic [ADDR_W-1:0]     mark_addr,
    output logic                  mark_wdata,
    input  logic                  mark_rdata
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int CNT_W = ADDR_W + 1;
    localparam int WV_W  = $clog2(MAX_WIDTH + 1);
    localparam int HV_W  = $clog2(MAX_HEIGHT + 1);

    fsg_state_t        state_reg, state_next;
    logic [ADDR_W-1:0] clr_reg, clr_next;
    logic [8:0]        col_reg, col_next;
    logic [7:0]        row_reg, row_next;
    logic [RADC_W-1:0] rad_reg, rad_next;
    logic [1:0]        mat_reg, mat_next;
    logic [1:0]        value_reg, value_next;
    logic              acc_reg, acc_next;
    logic [ADDR_W-1:0] i_reg, i_next;
    logic [WV_W-1:0]   x_reg, x_next;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic              below_reg, below_next;
    logic              left_reg, left_next;
    logic              right_reg, right_next;
    logic [CNT_W-1:0]  p_reg, p_next;
    logic              p_ok_reg, p_ok_next;
    logic [1:0]        cur_reg, cur_next;
    logic [1:0]        tgt_reg, tgt_next;
    logic [2:0]        c_reg, c_next;
    logic [ADDR_W-1:0] j_reg, j_next;
    logic [WV_W-1:0]   t_reg, t_next;
    logic [WV_W-1:0]   xlo_reg, xlo_next;
    logic [WV_W-1:0]   xhi_reg, xhi_next;
    logic [HV_W-1:0]   y_reg, y_next;
    logic [HV_W-1:0]   yhi_reg, yhi_next;
    logic [CNT_W-1:0]  base_reg, base_next;

    // effective grid size
    logic [15:0]     w16, h16;
    logic [WV_W-1:0] w_eff;
    logic [HV_W-1:0] h_eff;

    always_comb begin
        if (cfg_width == '0) begin
            w16 = 16'd1;
        end else if (16'(cfg_width) > 16'(MAX_WIDTH)) begin
            w16 = 16'(MAX_WIDTH);
        end else begin
            w16 = 16'(cfg_width);
        end
        if (cfg_height == '0) begin
            h16 = 16'd1;
        end else if (16'(cfg_height) > 16'(MAX_HEIGHT)) begin
            h16 = 16'(MAX_HEIGHT);
        end else begin
            h16 = 16'(cfg_height);
        end
        w_eff = w16[WV_W-1:0];
        h_eff = h16[HV_W-1:0];
    end

    // candidate selection for the cell under visit
    logic [4:0]       cand_mask;
    logic [4:0]       cand_avail;
    logic             cand_any;
    logic [2:0]       cand_sel;
    logic [CNT_W-1:0] cand_addr;
    logic             is_water;

    always_comb begin
        is_water = (cur_reg == CELL_WATER);
        cand_mask = {right_reg && is_water, left_reg && is_water,
                     below_reg && right_reg, below_reg && left_reg, below_reg};
        for (int k = 0; k < 5; k++) begin
            cand_avail[k] = cand_mask[k] && (3'(k) >= c_reg);
        end
        cand_any = |cand_avail;
        cand_sel = CAND_BELOW;
        for (int k = 4; k >= 0; k--) begin
            if (cand_avail[k]) begin
                cand_sel = 3'(k);
            end
        end
        unique case (cand_sel)
            CAND_BELOW:  cand_addr = CNT_W'(i_reg) + CNT_W'(w_eff);
            CAND_BLEFT:  cand_addr = CNT_W'(i_reg) + CNT_W'(w_eff) - CNT_W'(1);
            CAND_BRIGHT: cand_addr = CNT_W'(i_reg) + CNT_W'(w_eff) + CNT_W'(1);
            CAND_LEFT:   cand_addr = CNT_W'(i_reg) - CNT_W'(1);
            CAND_RIGHT:  cand_addr = CNT_W'(i_reg) + CNT_W'(1);
            default:     cand_addr = CNT_W'(i_reg);
        endcase
    end

    // paint window bounds
    logic [15:0] cx16, cy16, rr16, xl16, xh16, yl16, yh16;

    always_comb begin
        cx16 = 16'(col_reg);
        cy16 = 16'(row_reg);
        rr16 = 16'(rad_reg);
        xl16 = (cx16 > rr16) ? cx16 - rr16 : 16'd0;
        xh16 = (cx16 + rr16 < w16) ? cx16 + rr16 : w16 - 16'd1;
        yl16 = (cy16 > rr16) ? cy16 - rr16 : 16'd0;
        yh16 = (cy16 + rr16 < h16) ? cy16 + rr16 : h16 - 16'd1;
    end

    logic [CNT_W-1:0] paint_addr;
    logic             sand_ok, water_ok, tgt_ok;

    always_comb begin
        paint_addr = base_reg + CNT_W'(x_reg);
        sand_ok  = !mark_rdata && (cell_rdata == CELL_EMPTY || cell_rdata == CELL_WATER);
        water_ok = (cell_rdata == CELL_EMPTY);
        tgt_ok   = is_water ? water_ok : sand_ok;
    end

    always_comb begin
        state_next = state_reg;
        clr_next   = clr_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        rad_next   = rad_reg;
        mat_next   = mat_reg;
        value_next = value_reg;
        acc_next   = acc_reg;
        i_next     = i_reg;
        x_next     = x_reg;
        n_next     = n_reg;
        below_next = below_reg;
        left_next  = left_reg;
        right_next = right_reg;
        p_next     = p_reg;
        p_ok_next  = p_ok_reg;
        cur_next   = cur_reg;
        tgt_next   = tgt_reg;
        c_next     = c_reg;
        j_next     = j_reg;
        t_next     = t_reg;
        xlo_next   = xlo_reg;
        xhi_next   = xhi_reg;
        y_next     = y_reg;
        yhi_next   = yhi_reg;
        base_next  = base_reg;
        cell_en    = 1'b0;
        cell_we    = 1'b0;
        cell_addr  = '0;
        cell_wdata = CELL_EMPTY;
        mark_en    = 1'b0;
        mark_we    = 1'b0;
        mark_addr  = '0;
        mark_wdata = 1'b0;
        res_valid  = 1'b0;

        unique case (state_reg)
            ST_CLEAR: begin
                cell_en   = 1'b1;
                cell_we   = 1'b1;
                cell_addr = clr_reg;
                mark_en   = 1'b1;
                mark_we   = 1'b1;
                mark_addr = clr_reg;
                if (clr_reg == ADDR_W'(DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end else begin
                    clr_next = clr_reg + ADDR_W'(1);
                end
            end
            ST_IDLE: begin
                if (start) begin
                    col_next   = item.col;
                    row_next   = item.row;
                    mat_next   = item.material;
                    rad_next   = (16'(item.radius) > 16'(MAX_RADIUS)) ?
                                 RADC_W'(MAX_RADIUS) : RADC_W'(item.radius);
                    value_next = CELL_EMPTY;
                    acc_next   = 1'b0;
                    priority case (item.command)
                        CMD_SWEEP: begin
                            acc_next   = 1'b1;
                            state_next = ST_SWEEP_INIT;
                        end
                        CMD_PAINT, CMD_READ: begin
                            if (16'(item.col) < w16 && 16'(item.row) < h16) begin
                                acc_next   = 1'b1;
                                state_next = (item.command == CMD_PAINT) ?
                                             ST_PAINT_INIT : ST_READ;
                            end else begin
                                state_next = ST_DONE;
                            end
                        end
                        default: state_next = ST_DONE;
                    endcase
                end
            end
            ST_READ: begin
                cell_en    = 1'b1;
                cell_addr  = ADDR_W'(CNT_W'(row_reg) * CNT_W'(w_eff) + CNT_W'(col_reg));
                state_next = ST_READ_WAIT;
            end
            ST_READ_WAIT: begin
                value_next = cell_rdata;
                state_next = ST_DONE;
            end
            ST_PAINT_INIT: begin
                xlo_next   = xl16[WV_W-1:0];
                xhi_next   = xh16[WV_W-1:0];
                x_next     = xl16[WV_W-1:0];
                y_next     = yl16[HV_W-1:0];
                yhi_next   = yh16[HV_W-1:0];
                state_next = ST_PAINT_BASE;
            end
            ST_PAINT_BASE: begin
                base_next  = CNT_W'(y_reg) * CNT_W'(w_eff);
                state_next = ST_PAINT_RD;
            end
            ST_PAINT_RD, ST_PAINT_CHK: begin
                cell_addr  = ADDR_W'(paint_addr);
                cell_wdata = mat_reg;
                if (state_reg == ST_PAINT_RD && mat_reg != CELL_EMPTY) begin
                    cell_en    = 1'b1;
                    state_next = ST_PAINT_CHK;
                end else begin
                    // erase writes blindly; otherwise fill only empty cells
                    cell_en = (mat_reg == CELL_EMPTY) || (cell_rdata == CELL_EMPTY);
                    cell_we = 1'b1;
                    if (x_reg == xhi_reg) begin
                        if (y_reg == yhi_reg) begin
                            state_next = ST_DONE;
                        end else begin
                            y_next     = y_reg + HV_W'(1);
                            base_next  = base_reg + CNT_W'(w_eff);
                            x_next     = xlo_reg;
                            state_next = ST_PAINT_RD;
                        end
                    end else begin
                        x_next     = x_reg + WV_W'(1);
                        state_next = ST_PAINT_RD;
                    end
                end
            end
            ST_SWEEP_INIT: begin
                n_next     = CNT_W'(w_eff) * CNT_W'(h_eff);
                state_next = ST_SWEEP_START;
            end
            ST_SWEEP_START: begin
                i_next     = ADDR_W'(n_reg - CNT_W'(1));
                x_next     = w_eff - WV_W'(1);
                state_next = ST_VISIT_RD;
            end
            ST_VISIT_RD: begin
                cell_en    = 1'b1;
                cell_addr  = i_reg;
                mark_en    = 1'b1;
                mark_addr  = i_reg;
                below_next = (CNT_W'(i_reg) + CNT_W'(w_eff)) < n_reg;
                left_next  = (x_reg != '0);
                right_next = (16'(x_reg) + 16'd1) < w16;
                p_next     = CNT_W'(i_reg) + CNT_W'(w_eff) + CNT_W'(1);
                p_ok_next  = (CNT_W'(i_reg) + CNT_W'(w_eff) + CNT_W'(1)) < n_reg;
                state_next = ST_VISIT_CHK;
            end
            ST_VISIT_CHK, ST_MARK_CLR: begin
                cur_next = cell_rdata;
                c_next   = CAND_BELOW;
                if (state_reg == ST_VISIT_CHK && !mark_rdata &&
                    ((cell_rdata == CELL_SAND && below_reg) || cell_rdata == CELL_WATER)) begin
                    state_next = ST_CAND_SEL;
                end else begin
                    // mark at i+w+1 is dead once cell i is done
                    if (state_reg == ST_MARK_CLR) begin
                        cur_next = cur_reg;
                    end
                    mark_en   = p_ok_reg;
                    mark_we   = 1'b1;
                    mark_addr = ADDR_W'(p_reg);
                    if (i_reg == '0) begin
                        t_next     = w_eff;
                        state_next = ST_TAIL_CLR;
                    end else begin
                        i_next     = i_reg - ADDR_W'(1);
                        x_next     = (x_reg == '0) ? w_eff - WV_W'(1) : x_reg - WV_W'(1);
                        state_next = ST_VISIT_RD;
                    end
                end
            end
            ST_CAND_SEL: begin
                if (cand_any) begin
                    cell_en    = 1'b1;
                    cell_addr  = ADDR_W'(cand_addr);
                    mark_en    = 1'b1;
                    mark_addr  = ADDR_W'(cand_addr);
                    j_next     = ADDR_W'(cand_addr);
                    c_next     = cand_sel;
                    state_next = ST_CAND_CHK;
                end else begin
                    state_next = ST_MARK_CLR;
                end
            end
            ST_CAND_CHK: begin
                if (tgt_ok) begin
                    cell_en    = 1'b1;
                    cell_we    = 1'b1;
                    cell_addr  = j_reg;
                    cell_wdata = cur_reg;
                    mark_en    = 1'b1;
                    mark_we    = 1'b1;
                    mark_addr  = j_reg;
                    mark_wdata = 1'b1;
                    tgt_next   = cell_rdata;
                    state_next = ST_MOVE_SRC;
                end else begin
                    c_next     = c_reg + 3'd1;
                    state_next = ST_CAND_SEL;
                end
            end
            ST_MOVE_SRC: begin
                cell_en    = 1'b1;
                cell_we    = 1'b1;
                cell_addr  = i_reg;
                cell_wdata = tgt_reg;
                mark_en    = 1'b1;
                mark_we    = 1'b1;
                mark_addr  = i_reg;
                mark_wdata = (cur_reg == CELL_SAND) && (tgt_reg != CELL_EMPTY);
                state_next = ST_MARK_CLR;
            end
            ST_TAIL_CLR: begin
                // marks in the first row plus one are never retired in the sweep
                mark_en   = 1'b1;
                mark_we   = 1'b1;
                mark_addr = ADDR_W'(t_reg);
                if (t_reg == '0) begin
                    state_next = ST_DONE;
                end else begin
                    t_next = t_reg - WV_W'(1);
                end
            end
            ST_DONE: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
        end
    end

    always_ff @(posedge aclk) begin
        col_reg   <= col_next;
        row_reg   <= row_next;
        rad_reg   <= rad_next;
        mat_reg   <= mat_next;
        value_reg <= value_next;
        acc_reg   <= acc_next;
        i_reg     <= i_next;
        x_reg     <= x_next;
        n_reg     <= n_next;
        below_reg <= below_next;
        left_reg  <= left_next;
        right_reg <= right_next;
        p_reg     <= p_next;
        p_ok_reg  <= p_ok_next;
        cur_reg   <= cur_next;
        tgt_reg   <= tgt_next;
        c_reg     <= c_next;
        j_reg     <= j_next;
        t_reg     <= t_next;
        xlo_reg   <= xlo_next;
        xhi_reg   <= xhi_next;
        y_reg     <= y_next;
        yhi_reg   <= yhi_next;
        base_reg  <= base_next;
    end

    assign idle           = (state_reg == ST_IDLE);
    assign res.cell_value = value_reg;
    assign res.accepted   = acc_reg;

endmodule

// ===== rtl/falling_sand_grid_engine_unit.sv =====
// Top level of the falling sand grid engine: config registers, output register,
// cell and mark RAMs. Depends on fsg_pkg, fsg_ram, fsg_ctrl and the defines header.
//
//  channel  | handshake         | payload
//  ---------+-------------------+------------------------------
//  s_       | s_valid / s_ready | s_item   (fsg_in_t)
//  m_       | m_valid / m_ready | m_item   (fsg_out_t)
//  cfg_     | cfg_we            | cfg_index, cfg_wdata
//
// After reset both RAMs are zeroed with s_ready low. Sweep: each cell is read with
// its mark, a movable cell tries its candidates in order, and the marks of the
// first row plus one are cleared last. Paint: erase writes each cell in the
// clipped square; other materials read each cell first. One item is worked on at
// a time; its result waits in the output register while the next item is taken.
`include "falling_sand_grid_engine_unit_defines.svh"

module falling_sand_grid_engine_unit import fsg_pkg::*; #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 256,
    parameter int MAX_RADIUS = 50
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  fsg_in_t               s_item,
    output logic                  m_valid,
    input  logic                  m_ready,
    output fsg_out_t              m_item,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);

    logic [CFG_W_BITS-1:0] width_reg;
    logic [CFG_H_BITS-1:0] height_reg;
    logic                  m_valid_reg;
    fsg_out_t              m_item_reg;

    logic              idle, res_valid, res_ready;
    fsg_out_t          res;
    logic              cell_en, cell_we, mark_en, mark_we, mark_wdata, mark_rdata;
    logic [ADDR_W-1:0] cell_addr, mark_addr;
    logic [1:0]        cell_wdata, cell_rdata;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= CFG_W_BITS'(320);
            height_reg <= CFG_H_BITS'(180);
        end else if (cfg_we) begin
            priority case (cfg_index)
                REG_GRID_WIDTH:  width_reg  <= cfg_wdata[CFG_W_BITS-1:0];
                REG_GRID_HEIGHT: height_reg <= cfg_wdata[CFG_H_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_item_reg <= res;
        end
    end

    assign s_ready = idle;
    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    fsg_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_width  (width_reg),
        .cfg_height (height_reg),
        .start      (s_valid),
        .item       (s_item),
        .idle       (idle),
        .res_valid  (res_valid),
        .res        (res),
        .res_ready  (res_ready),
        .cell_en    (cell_en),
        .cell_we    (cell_we),
        .cell_addr  (cell_addr),
        .cell_wdata (cell_wdata),
        .cell_rdata (cell_rdata),
        .mark_en    (mark_en),
        .mark_we    (mark_we),
        .mark_addr  (mark_addr),
        .mark_wdata (mark_wdata),
        .mark_rdata (mark_rdata)
    );

    fsg_ram #(
        .DEPTH  (DEPTH),
        .DATA_W (2)
    ) u_cell_ram (
        .aclk  (aclk),
        .en    (cell_en),
        .we    (cell_we),
        .addr  (cell_addr),
        .wdata (cell_wdata),
        .rdata (cell_rdata)
    );

    fsg_ram #(
        .DEPTH  (DEPTH),
        .DATA_W (1)
    ) u_mark_ram (
        .aclk  (aclk),
        .en    (mark_en),
        .we    (mark_we),
        .addr  (mark_addr),
        .wdata (mark_wdata),
        .rdata (mark_rdata)
    );

    `FSG_ASSERT_NEXT(a_busy_after_accept, s_valid && s_ready, !s_ready, "item taken while busy")
    `FSG_ASSERT_NOW(a_idle_no_result, s_ready, !res_valid, "result shown while idle")
    `FSG_ASSERT_NOW(a_value_needs_accept, m_valid && (m_item.cell_value != CELL_EMPTY), m_item.accepted, "cell value on rejected item")

endmodule

// ===== dv/tb_top.sv =====
// Testbench for falling_sand_grid_engine_unit: a cell grid predictor, random and directed items.
// Depends on fsg_pkg and the RTL top; reads no files.
`timescale 1ns / 100ps

module tb_top;
    import fsg_pkg::*;

    localparam int GRID_W_MAX = 512;
    localparam int GRID_H_MAX = 256;
    localparam int RAD_MAX    = 50;
    localparam int CELLS      = GRID_W_MAX * GRID_H_MAX;
    localparam logic [1:0] CMD_NONE = 2'd3;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    fsg_in_t               s_item;
    logic                  m_valid;
    logic                  m_ready;
    fsg_out_t              m_item;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    falling_sand_grid_engine_unit DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_item(s_item),
        .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    // predictor state
    logic [1:0]      cell_mem [0:CELLS-1];
    bit              moved    [0:CELLS-1];
    logic [9:0]      width_reg;
    logic [8:0]      height_reg;
    fsg_out_t        pending_results [$];
    int              error_count;
    int              send_idle_pct;
    int              recv_idle_pct;

    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // result checker
    always @(posedge aclk) begin
        fsg_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected item", 1, 0);
            end else begin
                want = pending_results.pop_front();
                if (m_item.cell_value !== want.cell_value)
                    report_mismatch("cell_value", m_item.cell_value, want.cell_value);
                if (m_item.accepted !== want.accepted)
                    report_mismatch("accepted", m_item.accepted, want.accepted);
            end
        end
    end

    function automatic int eff_w();
        if (width_reg == 0) return 1;
        if (width_reg > GRID_W_MAX) return GRID_W_MAX;
        return width_reg;
    endfunction

    function automatic int eff_h();
        if (height_reg == 0) return 1;
        if (height_reg > GRID_H_MAX) return GRID_H_MAX;
        return height_reg;
    endfunction

    function automatic bit sand_can_enter(int j);
        return !moved[j] && (cell_mem[j] == CELL_EMPTY || cell_mem[j] == CELL_WATER);
    endfunction

    function automatic void swap_cells(int a, int b);
        logic [1:0] t;
        t = cell_mem[a];
        cell_mem[a] = cell_mem[b];
        cell_mem[b] = t;
    endfunction

    function automatic void sand_to(int i, int j);
        swap_cells(i, j);
        moved[j] = 1;
        if (cell_mem[i] != CELL_EMPTY) moved[i] = 1;
    endfunction

    function automatic void water_to(int i, int j);
        swap_cells(i, j);
        moved[j] = 1;
    endfunction

    function automatic void run_sweep();
        int w, n, x;
        bit below, lft, rgt;
        w = eff_w();
        n = w * eff_h();
        for (int k = 0; k < n; k++) moved[k] = 0;
        for (int i = n - 1; i >= 0; i--) begin
            x = i % w;
            below = (i + w) < n;
            lft = x > 0;
            rgt = (x + 1) < w;
            if (moved[i]) continue;
            if (cell_mem[i] == CELL_SAND) begin
                if (!below) continue;
                if (sand_can_enter(i + w)) sand_to(i, i + w);
                else if (lft && sand_can_enter(i + w - 1)) sand_to(i, i + w - 1);
                else if (rgt && sand_can_enter(i + w + 1)) sand_to(i, i + w + 1);
            end else if (cell_mem[i] == CELL_WATER) begin
                if (below && cell_mem[i + w] == CELL_EMPTY) water_to(i, i + w);
                else if (lft && below && cell_mem[i + w - 1] == CELL_EMPTY)
                    water_to(i, i + w - 1);
                else if (rgt && below && cell_mem[i + w + 1] == CELL_EMPTY)
                    water_to(i, i + w + 1);
                else if (lft && cell_mem[i - 1] == CELL_EMPTY) water_to(i, i - 1);
                else if (rgt && cell_mem[i + 1] == CELL_EMPTY) water_to(i, i + 1);
            end
        end
    endfunction

    function automatic void stamp_square(int cx, int cy, int r, logic [1:0] mat);
        int w, h, x, y, idx;
        w = eff_w();
        h = eff_h();
        for (int dy = -r; dy <= r; dy++) begin
            for (int dx = -r; dx <= r; dx++) begin
                x = cx + dx;
                y = cy + dy;
                if (x < 0 || x >= w || y < 0 || y >= h) continue;
                idx = y * w + x;
                if (cell_mem[idx] == CELL_EMPTY || mat == CELL_EMPTY) cell_mem[idx] = mat;
            end
        end
    endfunction

    function automatic fsg_out_t apply_command(fsg_in_t it);
        fsg_out_t res;
        int w, r;
        bit in_grid;
        w = eff_w();
        in_grid = it.col < w && it.row < eff_h();
        res = '0;
        case (it.command)
            CMD_SWEEP: begin
                run_sweep();
                res.accepted = 1'b1;
            end
            CMD_PAINT: if (in_grid) begin
                r = (it.radius > RAD_MAX) ? RAD_MAX : it.radius;
                stamp_square(it.col, it.row, r, it.material);
                res.accepted = 1'b1;
            end
            CMD_READ: if (in_grid) begin
                res.cell_value = cell_mem[it.row * w + it.col];
                res.accepted = 1'b1;
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic send_item(input logic [1:0] cmd, input int col, input int row,
                             input int rad, input logic [1:0] mat);
        fsg_in_t it;
        it.command = cmd;
        it.col = col[8:0];
        it.row = row[7:0];
        it.radius = rad[5:0];
        it.material = mat;
        s_valid <= 1'b1;
        s_item <= it;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(apply_command(it));
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value[CFG_DATA_W-1:0];
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == REG_GRID_WIDTH) width_reg = value[9:0];
        else height_reg = value[8:0];
    endtask

    task automatic set_size(input int w, input int h);
        write_reg(REG_GRID_WIDTH, w);
        write_reg(REG_GRID_HEIGHT, h);
    endtask

    // reset size 320x180; the grid starts empty
    task automatic test_reset_size();
        send_item(CMD_READ, 0, 0, 0, CELL_STONE);
        send_item(CMD_READ, 319, 179, 0, CELL_EMPTY);
        send_item(CMD_READ, 320, 0, 0, CELL_EMPTY);
        send_item(CMD_READ, 0, 180, 0, CELL_EMPTY);
        send_item(CMD_PAINT, 319, 179, 63, CELL_STONE);  // radius saturates
        send_item(CMD_PAINT, 10, 100, 2, CELL_SAND);
        send_item(CMD_PAINT, 20, 100, 1, CELL_WATER);
        send_item(CMD_NONE, 5, 5, 5, CELL_SAND);
        send_item(CMD_SWEEP, 0, 0, 0, CELL_EMPTY);
        send_item(CMD_READ, 10, 103, 0, CELL_EMPTY);
        send_item(CMD_READ, 20, 102, 0, CELL_EMPTY);
        send_item(CMD_READ, 300, 170, 0, CELL_EMPTY);
    endtask

    // small grid: every command, overwrite rule, erase, out of grid, bottom row
    task automatic test_small_grid();
        set_size(8, 6);
        send_item(CMD_PAINT, 0, 0, 63, CELL_EMPTY);
        send_item(CMD_PAINT, 3, 5, 1, CELL_STONE);
        send_item(CMD_PAINT, 3, 1, 1, CELL_SAND);
        send_item(CMD_PAINT, 3, 2, 2, CELL_WATER);  // only empty cells take it
        send_item(CMD_PAINT, 511, 255, 3, CELL_SAND);
        send_item(CMD_PAINT, 7, 5, 0, CELL_SAND);
        for (int i = 0; i < 4; i++) send_item(CMD_SWEEP, 0, 0, 0, CELL_EMPTY);
        send_item(CMD_READ, 3, 4, 0, CELL_EMPTY);
        send_item(CMD_READ, 7, 5, 0, CELL_EMPTY);
        send_item(CMD_READ, 511, 255, 0, CELL_EMPTY);
        send_item(CMD_PAINT, 4, 4, 1, CELL_EMPTY);
        send_item(CMD_READ, 4, 4, 0, CELL_EMPTY);
        // old contents read again as rows of a new width
        write_reg(REG_GRID_WIDTH, 5);
        send_item(CMD_READ, 4, 7, 0, CELL_EMPTY);
        send_item(CMD_SWEEP, 0, 0, 0, CELL_EMPTY);
        send_item(CMD_READ, 2, 9, 0, CELL_EMPTY);
    endtask

    task automatic test_extreme_sizes();
        set_size(0, 0);
        send_item(CMD_PAINT, 0, 0, 0, CELL_SAND);
        send_item(CMD_SWEEP, 0, 0, 0, CELL_EMPTY);
        send_item(CMD_READ, 0, 0, 0, CELL_EMPTY);
        send_item(CMD_READ, 1, 0, 0, CELL_EMPTY);
        set_size(1023, 1);
        send_item(CMD_PAINT, 511, 0, 0, CELL_WATER);
        send_item(CMD_PAINT, 256, 0, 0, CELL_WATER);
        send_item(CMD_SWEEP, 0, 0, 0, CELL_EMPTY);
        send_item(CMD_READ, 510, 0, 0, CELL_EMPTY);
        send_item(CMD_READ, 255, 0, 0, CELL_EMPTY);
        set_size(1, 511);
        send_item(CMD_PAINT, 0, 250, 3, CELL_SAND);
        send_item(CMD_SWEEP, 0, 0, 0, CELL_EMPTY);
        send_item(CMD_READ, 0, 255, 0, CELL_EMPTY);
        send_item(CMD_READ, 0, 250, 0, CELL_EMPTY);
    endtask

    task automatic test_random(input int count);
        int w, h, c, r, roll;
        w = $urandom_range(2, 24);
        h = $urandom_range(2, 16);
        set_size(w, h);
        for (int i = 0; i < count; i++) begin
            roll = $urandom_range(99);
            if ($urandom_range(9) == 0) begin
                c = $urandom_range(511);
                r = $urandom_range(255);
            end else begin
                c = $urandom_range(w - 1);
                r = $urandom_range(h - 1);
            end
            if (roll < 35)
                send_item(CMD_PAINT, c, r,
                          ($urandom_range(7) == 0) ? $urandom_range(63) : $urandom_range(3),
                          $urandom_range(3));
            else if (roll < 60) send_item(CMD_SWEEP, c, r, $urandom_range(63), $urandom_range(3));
            else if (roll < 95) send_item(CMD_READ, c, r, $urandom_range(63), $urandom_range(3));
            else send_item(CMD_NONE, c, r, $urandom_range(63), $urandom_range(3));
        end
    endtask

    initial begin
        for (int k = 0; k < CELLS; k++) begin
            cell_mem[k] = CELL_EMPTY;
            moved[k] = 0;
        end
        width_reg = 10'd320;
        height_reg = 9'd180;
        error_count = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_item = '0;
        m_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct = 32;
        recv_idle_pct = 77;
        test_reset_size();
        test_small_grid();
        test_random(20);
        send_idle_pct = 77;
        recv_idle_pct = 32;
        test_extreme_sizes();
        test_random(20);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(20);

        wait_idle();
        repeat (50) @(posedge aclk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #40ms;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/fsg_pkg.sv
rtl/fsg_ram.sv
rtl/fsg_ctrl.sv
rtl/falling_sand_grid_engine_unit.sv
dv/tb_top.sv
